/* rtl/wsss_pkg.sv */
// Shared types, codes and helpers for the shake step sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package wsss_pkg;

    // Command codes carried on the input tuser
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_POLL  = 2'd0;
    localparam cmd_t CMD_START = 2'd1;
    localparam cmd_t CMD_STOP  = 2'd2;

    // Configuration register indexes
    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t CFG_WELL_X           = 3'd0;
    localparam cfg_index_t CFG_Z_BOTTOM         = 3'd1;
    localparam cfg_index_t CFG_WAIT_AFTER_X     = 3'd2;
    localparam cfg_index_t CFG_WAIT_AT_BOTTOM   = 3'd3;
    localparam cfg_index_t CFG_SHAKE_TIME       = 3'd4;
    localparam cfg_index_t CFG_WAIT_AFTER_SHAKE = 3'd5;
    localparam cfg_index_t CFG_WAIT_AT_TOP      = 3'd6;

    // Phase codes as reported on phase_out
    typedef logic [2:0] phase_code_t;
    localparam phase_code_t PC_IDLE   = 3'd0;
    localparam phase_code_t PC_START  = 3'd1;
    localparam phase_code_t PC_MOVE_X = 3'd2;
    localparam phase_code_t PC_WAIT   = 3'd3;
    localparam phase_code_t PC_LOWER  = 3'd4;
    localparam phase_code_t PC_SHAKE  = 3'd5;
    localparam phase_code_t PC_RAISE  = 3'd6;
    localparam phase_code_t PC_FINISH = 3'd7;

    // One-hot phase machine encoding
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_START  = 8'b0000_0010,
        PH_MOVE_X = 8'b0000_0100,
        PH_WAIT   = 8'b0000_1000,
        PH_LOWER  = 8'b0001_0000,
        PH_SHAKE  = 8'b0010_0000,
        PH_RAISE  = 8'b0100_0000,
        PH_FINISH = 8'b1000_0000
    } phase_t;

    // Configuration as seen by the step logic; waits are held as tick spans
    typedef struct packed {
        logic [31:0] well_x;
        logic [31:0] z_bottom;
        logic [31:0] span_after_x;
        logic [31:0] span_at_bottom;
        logic [31:0] span_shake;
        logic [31:0] span_after_shake;
        logic [31:0] span_at_top;
    } cfg_t;

    typedef struct packed {
        cmd_t        command;
        logic [31:0] now_ms;
        logic [31:0] x_position;
        logic [31:0] z_position;
    } item_t;

    typedef struct packed {
        logic        x_move_valid;
        logic [31:0] x_target;
        logic        z_move_valid;
        logic [31:0] z_target;
        logic        step_done;
        phase_code_t phase_out;
    } result_t;

    function automatic phase_code_t phase_code(input phase_t ph);
        phase_code_t code;
        case (ph)
            PH_IDLE:   code = PC_IDLE;
            PH_START:  code = PC_START;
            PH_MOVE_X: code = PC_MOVE_X;
            PH_WAIT:   code = PC_WAIT;
            PH_LOWER:  code = PC_LOWER;
            PH_SHAKE:  code = PC_SHAKE;
            PH_RAISE:  code = PC_RAISE;
            PH_FINISH: code = PC_FINISH;
            default:   code = PC_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/wsss_cfg.sv */
// Configuration register file of the shake step sequencer.
// Depends on wsss_pkg; wait times are turned into tick spans on write.
`default_nettype none

module wsss_cfg #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire wsss_pkg::cfg_index_t  wr_index,
    input  wire logic [31:0]           wr_data,
    output wsss_pkg::cfg_t             cfg
);

    localparam logic [31:0] TICKS = 32'(TICKS_PER_SECOND);

    wsss_pkg::cfg_t cfg_reg;
    wsss_pkg::cfg_t cfg_next;
    logic [31:0]    span;

    // Low 16 bits of the seconds value times ticks per second, kept modulo 2^32
    assign span = 32'({16'd0, wr_data[15:0]} * TICKS);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                wsss_pkg::CFG_WELL_X:           cfg_next.well_x           = wr_data;
                wsss_pkg::CFG_Z_BOTTOM:         cfg_next.z_bottom         = wr_data;
                wsss_pkg::CFG_WAIT_AFTER_X:     cfg_next.span_after_x     = span;
                wsss_pkg::CFG_WAIT_AT_BOTTOM:   cfg_next.span_at_bottom   = span;
                wsss_pkg::CFG_SHAKE_TIME:       cfg_next.span_shake       = span;
                wsss_pkg::CFG_WAIT_AFTER_SHAKE: cfg_next.span_after_shake = span;
                wsss_pkg::CFG_WAIT_AT_TOP:      cfg_next.span_at_top      = span;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/wsss_core.sv */
// Phase machine and single-pass step logic of the shake step sequencer.
// Depends on wsss_pkg; state advances once per stepped item.
`default_nettype none

module wsss_core #(
    parameter int SHAKE_LIFT = 1000
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire wsss_pkg::item_t   item,
    input  wire wsss_pkg::cfg_t    cfg,
    output wsss_pkg::result_t      result
);

    localparam logic [31:0] LIFT = 32'(SHAKE_LIFT);

    wsss_pkg::phase_t phase_reg, phase_next;
    wsss_pkg::phase_t prior_reg, prior_next;
    logic [31:0]      deadline_reg, deadline_next;

    logic [31:0] lifted;
    logic        expired;
    logic        load_deadline;
    logic [31:0] span_sel;
    logic        x_mv, z_mv, done;
    logic [31:0] x_tgt, z_tgt;

    assign lifted  = cfg.z_bottom - LIFT;
    assign expired = item.now_ms > deadline_reg;

    always_comb begin
        phase_next    = phase_reg;
        prior_next    = prior_reg;
        load_deadline = 1'b0;
        span_sel      = cfg.span_after_x;
        x_mv          = 1'b0;
        z_mv          = 1'b0;
        done          = 1'b0;
        x_tgt         = '0;
        z_tgt         = '0;
        case (item.command)
            wsss_pkg::CMD_START: begin
                if (phase_reg == wsss_pkg::PH_IDLE) begin
                    phase_next = wsss_pkg::PH_START;
                end
            end
            wsss_pkg::CMD_STOP: begin
                phase_next = wsss_pkg::PH_IDLE;
            end
            wsss_pkg::CMD_POLL: begin
                case (phase_reg)
                    wsss_pkg::PH_START: begin
                        x_mv       = 1'b1;
                        x_tgt      = cfg.well_x;
                        prior_next = wsss_pkg::PH_START;
                        phase_next = wsss_pkg::PH_MOVE_X;
                    end
                    wsss_pkg::PH_MOVE_X: begin
                        if (item.x_position == cfg.well_x) begin
                            prior_next    = wsss_pkg::PH_MOVE_X;
                            phase_next    = wsss_pkg::PH_WAIT;
                            load_deadline = 1'b1;
                            span_sel      = cfg.span_after_x;
                        end
                    end
                    wsss_pkg::PH_WAIT: begin
                        if (expired) begin
                            case (prior_reg)
                                wsss_pkg::PH_MOVE_X: begin
                                    z_mv       = 1'b1;
                                    z_tgt      = cfg.z_bottom;
                                    phase_next = wsss_pkg::PH_LOWER;
                                end
                                wsss_pkg::PH_LOWER: begin
                                    z_mv          = 1'b1;
                                    z_tgt         = lifted;
                                    load_deadline = 1'b1;
                                    span_sel      = cfg.span_shake;
                                    phase_next    = wsss_pkg::PH_SHAKE;
                                end
                                wsss_pkg::PH_SHAKE: begin
                                    z_mv       = 1'b1;
                                    z_tgt      = '0;
                                    phase_next = wsss_pkg::PH_RAISE;
                                end
                                wsss_pkg::PH_RAISE: begin
                                    phase_next = wsss_pkg::PH_FINISH;
                                end
                                default: ;
                            endcase
                        end
                    end
                    wsss_pkg::PH_LOWER: begin
                        if (item.z_position == cfg.z_bottom) begin
                            prior_next    = wsss_pkg::PH_LOWER;
                            phase_next    = wsss_pkg::PH_WAIT;
                            load_deadline = 1'b1;
                            span_sel      = cfg.span_at_bottom;
                        end
                    end
                    wsss_pkg::PH_SHAKE: begin
                        if (item.z_position == lifted) begin
                            z_mv  = 1'b1;
                            z_tgt = cfg.z_bottom;
                        end else if (item.z_position == cfg.z_bottom) begin
                            if (expired) begin
                                prior_next    = wsss_pkg::PH_SHAKE;
                                phase_next    = wsss_pkg::PH_WAIT;
                                load_deadline = 1'b1;
                                span_sel      = cfg.span_after_shake;
                            end else begin
                                z_mv  = 1'b1;
                                z_tgt = lifted;
                            end
                        end
                    end
                    wsss_pkg::PH_RAISE: begin
                        if (item.z_position == '0) begin
                            prior_next    = wsss_pkg::PH_RAISE;
                            phase_next    = wsss_pkg::PH_WAIT;
                            load_deadline = 1'b1;
                            span_sel      = cfg.span_at_top;
                        end
                    end
                    wsss_pkg::PH_FINISH: begin
                        prior_next = wsss_pkg::PH_FINISH;
                        phase_next = wsss_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign deadline_next = load_deadline ? (item.now_ms + span_sel) : deadline_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= wsss_pkg::PH_IDLE;
            prior_reg    <= wsss_pkg::PH_IDLE;
            deadline_reg <= '0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            prior_reg    <= prior_next;
            deadline_reg <= deadline_next;
        end
    end

    assign result.x_move_valid = x_mv;
    assign result.x_target     = x_tgt;
    assign result.z_move_valid = z_mv;
    assign result.z_target     = z_tgt;
    assign result.step_done    = done;
    assign result.phase_out    = wsss_pkg::phase_code(phase_next);

endmodule

`default_nettype wire

/* rtl/well_shake_step_sequencer.sv */
// Top level of the shake step sequencer: stream ports, input and result registers.
// Depends on wsss_pkg, wsss_cfg and wsss_core.
`default_nettype none

// Each input beat is a start, a stop or a poll carrying the millisecond count
// and the current X and Z positions; every beat yields exactly one result beat
// with any new X or Z target, a done flag and the phase after the beat.
// Throughput is one beat per cycle while m_tready stays high. A result beat
// goes from the input register through the single-pass step logic into the
// result register, which presents it on m_*; a wait on m_tready can hold it
// in the input register. While a result waits on m_tready, the input register
// still takes one more beat; only then does s_tready drop until the result
// drains. Wait times are converted to tick spans when written, so configuration
// must only be written while no beat is in flight.
module well_shake_step_sequencer #(
    parameter int SHAKE_LIFT       = 1000,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] now_ms, [63:32] x_position, [95:64] z_position
    input  wire logic [95:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] x_move_valid, [32:1] x_target, [33] z_move_valid, [65:34] z_target,
    // [66] step_done, [69:67] phase_out, [71:70] zero
    output logic [71:0]      m_tdata,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    wsss_pkg::cfg_t    cfg;
    wsss_pkg::item_t   in_item_reg;
    wsss_pkg::result_t step_result;
    wsss_pkg::result_t out_res_reg;

    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s_accept;
    logic advance;

    // Registers are always writable
    assign cfg_ready = 1'b1;

    wsss_cfg #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held beat when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat; payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.command    <= s_tuser;
            in_item_reg.now_ms     <= s_tdata[31:0];
            in_item_reg.x_position <= s_tdata[63:32];
            in_item_reg.z_position <= s_tdata[95:64];
        end
    end

    // Step the phase machine exactly once per advanced beat
    wsss_core #(
        .SHAKE_LIFT(SHAKE_LIFT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.phase_out,
                       out_res_reg.step_done,
                       out_res_reg.z_target,
                       out_res_reg.z_move_valid,
                       out_res_reg.x_target,
                       out_res_reg.x_move_valid};

endmodule

`default_nettype wire
